@@ rtl/grm_pkg.sv @@
// Shared types, constants and table functions for the grid ray marching core.
// Used by grm_sine_rom, grm_div and grid_ray_march_core. No dependencies.
`default_nettype none
package grm_pkg;

  // Geometry and angle constants (angles in sixteenths of a degree).
  localparam int GRID_DIM      = 8;
  localparam int FULL_TURN     = 5760;
  localparam int HALF_TURN     = 2880;
  localparam int QUARTER_TURN  = 1440;
  localparam int SWEEP_HALF    = 480;
  localparam int FOV_UNITS     = 960;
  localparam int SCREEN_H      = 480;
  localparam int SCREEN_MID    = 240;
  localparam int TRIG_ONE      = 32767;
  localparam int SHADE_NUM     = 2550000;
  localparam int SHADE_BIAS    = 10000;
  localparam int HEIGHT_MAX    = 65535;
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // Configuration defaults and register indexes.
  localparam logic [63:0] MAP_RESET    = 64'd18411143706683220479;
  localparam logic [15:0] SCALE_RESET  = 16'd20000;
  localparam logic        REG_WALL_MAP = 1'b0;
  localparam logic        REG_SCALE    = 1'b1;

  // Default sizing.
  localparam int CELL_PIXELS_DEF = 60;
  localparam int DEPTH_LIMIT_DEF = 480;
  localparam int RAY_COUNT_DEF   = 120;

  typedef struct packed {
    logic [16:0] pos_x;
    logic [16:0] pos_y;
    logic [12:0] view_angle;
    logic [6:0]  ray_index;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic [2:0]         wall_col;
    logic [2:0]         wall_row;
    logic [8:0]         raw_depth;
    logic [7:0]         shade;
    logic [8:0]         corrected_depth;
    logic [15:0]        slice_height;
    logic signed [15:0] slice_top;
    logic [9:0]         slice_x;
  } out_t;

  // Quarter-wave table address and sign of a folded angle.
  typedef struct packed {
    logic        neg;
    logic [10:0] idx;
  } trig_addr_t;

  // Fold an angle below two full turns onto the quarter wave.
  function automatic trig_addr_t fold_angle(input logic [12:0] ang);
    logic [12:0] a;
    trig_addr_t  r;
    a = ang;
    if (a >= 13'(FULL_TURN)) a = a - 13'(FULL_TURN);
    r.neg = (a >= 13'(HALF_TURN));
    if (r.neg) a = a - 13'(HALF_TURN);
    if (a > 13'(QUARTER_TURN)) a = 13'(HALF_TURN) - a;
    r.idx = a[10:0];
    return r;
  endfunction

  // round(32767*sin(a*pi/2880)) through a Q30 Taylor series; elaboration only.
  function automatic logic [14:0] quarter_sine(input int a);
    longint unsigned t;
    longint unsigned t2;
    longint unsigned term;
    longint          sum;
    longint unsigned q;
    t    = (longint'(a) * PI_Q30) / HALF_TURN;
    t2   = (t * t) >> 30;
    sum  = longint'(t);
    // Odd powers of the series, each divided by the next two factorial factors.
    term = ((t * t2) >> 30) / 6;
    sum  = sum - longint'(term);
    term = ((term * t2) >> 30) / 20;
    sum  = sum + longint'(term);
    term = ((term * t2) >> 30) / 42;
    sum  = sum - longint'(term);
    term = ((term * t2) >> 30) / 72;
    sum  = sum + longint'(term);
    term = ((term * t2) >> 30) / 110;
    sum  = sum - longint'(term);
    term = ((term * t2) >> 30) / 156;
    sum  = sum + longint'(term);
    term = ((term * t2) >> 30) / 210;
    sum  = sum - longint'(term);
    if (sum < 0) sum = 0;
    q = (longint'(sum) * TRIG_ONE + (64'd1 << 29)) >> 30;
    if (q > TRIG_ONE) q = TRIG_ONE;
    return q[14:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/grm_sine_rom.sv @@
// Quarter-wave sine table with a registered, signed read port.
// Depends on grm_pkg for the table function and address type.
`default_nettype none
module grm_sine_rom
  import grm_pkg::*;
(
  input  wire logic              clk,
  input  wire trig_addr_t        addr,
  output logic signed [15:0]     data
);

  logic [14:0] rom_w [QUARTER_TURN + 1];

  // Table contents are fixed at elaboration.
  for (genvar g = 0; g <= QUARTER_TURN; g++) begin : g_rom
    localparam logic [14:0] VAL = quarter_sine(g);
    assign rom_w[g] = VAL;
  end

  // Registered read, sign applied on the way out.
  always_ff @(posedge clk) begin
    if (addr.neg) begin
      data <= -$signed({1'b0, rom_w[addr.idx]});
    end else begin
      data <= $signed({1'b0, rom_w[addr.idx]});
    end
  end

endmodule
`default_nettype wire

@@ rtl/grm_div.sv @@
// Shared 32-bit restoring divider, one quotient bit per cycle.
// Depends on grm_pkg only by convention of the project.
`default_nettype none
module grm_div
  import grm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] num,
  input  wire logic [31:0] den,
  output logic             done,
  output logic [31:0]      quo
);

  logic [31:0] rem;
  logic [31:0] den_r;
  logic [4:0]  cnt;
  logic        busy;
  logic [32:0] shifted;

  assign shifted = {rem, quo[31]};

  // One shift-and-subtract step per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem   <= '0;
        quo   <= num;
        den_r <= den;
        cnt   <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        if (shifted >= {1'b0, den_r}) begin
          rem <= 32'(shifted - {1'b0, den_r});
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= shifted[31:0];
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/grid_ray_march_core.sv @@
// Grid ray marching core: one ray per transaction, one result per transaction.
// Steps from input to out_valid: angle reduction, table lookups, cell placement, a march bounded
// by DEPTH_LIMIT, then cosine correction and the height and shade divisions; a zero corrected
// depth skips the height division, and a miss goes from the march straight to the result.
// Throughput: one transaction at a time; in_ready is high only while the sequencer idles.
// Reset (rst, synchronous): sequencer idle, no result held, map and scale defaults.
`default_nettype none
module grid_ray_march_core
  import grm_pkg::*;
#(
  parameter int CELL_PIXELS = CELL_PIXELS_DEF,
  parameter int DEPTH_LIMIT = DEPTH_LIMIT_DEF,
  parameter int RAY_COUNT   = RAY_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_t             out_data,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_data
);

  localparam int DW   = $clog2(DEPTH_LIMIT);
  localparam int SPW  = 34;
  localparam int CW   = 8;
  localparam int STEP = FOV_UNITS / RAY_COUNT;
  localparam int COL_PIXELS = SCREEN_H / RAY_COUNT;
  localparam longint SPAN_L = longint'(CELL_PIXELS) * 256 * TRIG_ONE;
  localparam logic signed [SPW-1:0] SPAN = SPW'(SPAN_L);
  localparam logic [DW-1:0] D_LAST = DW'(DEPTH_LIMIT - 1);

  typedef enum logic [12:0] {
    S_IDLE      = 13'b0000000000001,
    S_REDUCE    = 13'b0000000000010,
    S_TRIG_C    = 13'b0000000000100,
    S_TRIG_S    = 13'b0000000001000,
    S_TRIG_O    = 13'b0000000010000,
    S_TRIG_W    = 13'b0000000100000,
    S_NORM      = 13'b0000001000000,
    S_MARCH     = 13'b0000010000000,
    S_MUL       = 13'b0000100000000,
    S_CORR      = 13'b0001000000000,
    S_DIV_HT    = 13'b0010000000000,
    S_DIV_SHADE = 13'b0100000000000,
    S_FINISH    = 13'b1000000000000
  } state_t;

  state_t state;

  logic [63:0] wall_map;
  logic [15:0] height_scale;

  logic [16:0] px;
  logic [16:0] py;
  logic [17:0] ray_acc;
  logic [17:0] turn_acc;
  logic [12:0] offs;
  logic signed [15:0] cos_v;
  logic signed [15:0] sin_v;
  logic signed [15:0] co;
  logic signed [SPW-1:0] rem_x;
  logic signed [SPW-1:0] rem_y;
  logic signed [CW-1:0]  col;
  logic signed [CW-1:0]  row;
  logic [DW-1:0] d;
  logic [DW+14:0] prod;
  logic [DW+14:0] corr_sum;
  logic [2*DW-1:0] sq;
  logic [DW-1:0] corr;
  logic div_wait;
  out_t res;
  out_t res_init;

  trig_addr_t rom_addr;
  logic signed [15:0] rom_q;

  logic        div_start;
  logic [31:0] div_num;
  logic [31:0] div_den;
  logic        div_done;
  logic [31:0] div_quo;

  logic signed [SPW-1:0] step_x;
  logic signed [SPW-1:0] step_y;
  logic signed [SPW-1:0] nx;
  logic signed [SPW-1:0] ny;
  logic outside;
  logic wall;
  logic co_pos;
  logic [16:0] turn_in;
  logic [12:0] view_in;
  logic [13:0] offs_raw;

  grm_sine_rom u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_q)
  );

  grm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign in_ready = (state == S_IDLE);
  assign co_pos   = (co > 16'sd0);

  // Angle setup for a new transaction.
  assign turn_in  = 17'(STEP * in_data.ray_index);
  assign view_in  = (in_data.view_angle >= 13'(FULL_TURN)) ?
                    in_data.view_angle - 13'(FULL_TURN) : in_data.view_angle;
  assign offs_raw = 14'(FULL_TURN + SWEEP_HALF) - 14'(turn_acc);

  // Cleared result with the slice column already filled in.
  always_comb begin
    res_init         = '0;
    res_init.slice_x = 10'(SCREEN_H + COL_PIXELS * in_data.ray_index);
  end

  // Table address for each lookup step.
  always_comb begin
    case (state)
      S_TRIG_C: rom_addr = fold_angle(ray_acc[12:0] + 13'(QUARTER_TURN));
      S_TRIG_S: rom_addr = fold_angle(ray_acc[12:0]);
      S_TRIG_O: rom_addr = fold_angle(offs + 13'(QUARTER_TURN));
      default:  rom_addr = fold_angle(13'd0);
    endcase
  end

  // Per-step position advance with a single cell correction.
  assign step_x = SPW'(cos_v) <<< 8;
  assign step_y = -(SPW'(sin_v) <<< 8);
  assign nx = rem_x + step_x;
  assign ny = rem_y + step_y;

  // Wall test of the current cell; off the grid counts as a wall.
  assign outside = (col < 0) || (row < 0) ||
                   (col >= CW'(GRID_DIM)) || (row >= CW'(GRID_DIM));
  assign wall = outside || wall_map[{row[2:0], col[2:0]}];

  // Division by 2^15-1: adding the product's upper part and one makes the shift exact.
  assign corr_sum = prod + (prod >> 15) + (DW + 15)'(1);

  // Divider operand selection.
  always_comb begin
    case (state)
      S_DIV_HT: begin
        div_num   = 32'(height_scale);
        div_den   = 32'(corr);
        div_start = (corr != '0) && !div_wait;
      end
      S_DIV_SHADE: begin
        div_num   = 32'(SHADE_NUM);
        div_den   = 32'(SHADE_BIAS) + 32'(sq);
        div_start = !div_wait;
      end
      default: begin
        div_num   = '0;
        div_den   = '0;
        div_start = 1'b0;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wall_map     <= MAP_RESET;
      height_scale <= SCALE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WALL_MAP: wall_map     <= cfg_data;
        REG_SCALE:    height_scale <= cfg_data[15:0];
        default:      ;
      endcase
    end
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      div_wait  <= 1'b0;
    end else begin
      if (state == S_FINISH && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      if (div_start) div_wait <= 1'b1;
      else if (div_done) div_wait <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            px       <= in_data.pos_x;
            py       <= in_data.pos_y;
            ray_acc  <= 18'(view_in) + 18'(FULL_TURN - SWEEP_HALF) + 18'(turn_in);
            turn_acc <= 18'(turn_in);
            res      <= res_init;
            state    <= S_REDUCE;
          end
        end
        S_REDUCE: begin
          if (ray_acc >= 18'(FULL_TURN)) ray_acc <= ray_acc - 18'(FULL_TURN);
          if (turn_acc >= 18'(FULL_TURN)) turn_acc <= turn_acc - 18'(FULL_TURN);
          if (ray_acc < 18'(FULL_TURN) && turn_acc < 18'(FULL_TURN)) state <= S_TRIG_C;
        end
        S_TRIG_C: begin
          offs  <= (offs_raw >= 14'(FULL_TURN)) ? 13'(offs_raw - 14'(FULL_TURN))
                                                : offs_raw[12:0];
          state <= S_TRIG_S;
        end
        S_TRIG_S: begin
          cos_v <= rom_q;
          state <= S_TRIG_O;
        end
        S_TRIG_O: begin
          sin_v <= rom_q;
          state <= S_TRIG_W;
        end
        S_TRIG_W: begin
          co    <= rom_q;
          rem_x <= $signed({2'b00, 32'(px) * 32'(TRIG_ONE)});
          rem_y <= $signed({2'b00, 32'(py) * 32'(TRIG_ONE)});
          col   <= '0;
          row   <= '0;
          d     <= '0;
          state <= S_NORM;
        end
        S_NORM: begin
          if (rem_x >= SPAN) begin
            rem_x <= rem_x - SPAN;
            col   <= col + CW'(1);
          end
          if (rem_y >= SPAN) begin
            rem_y <= rem_y - SPAN;
            row   <= row + CW'(1);
          end
          if (rem_x < SPAN && rem_y < SPAN) state <= S_MARCH;
        end
        S_MARCH: begin
          if (wall) begin
            res.hit       <= 1'b1;
            res.wall_col  <= (col < 0) ? 3'd0 :
                             (col >= CW'(GRID_DIM)) ? 3'(GRID_DIM - 1) : col[2:0];
            res.wall_row  <= (row < 0) ? 3'd0 :
                             (row >= CW'(GRID_DIM)) ? 3'(GRID_DIM - 1) : row[2:0];
            res.raw_depth <= 9'(d);
            state         <= S_MUL;
          end else if (d == D_LAST) begin
            state <= S_FINISH;
          end else begin
            d <= d + DW'(1);
            if (nx >= SPAN) begin
              rem_x <= nx - SPAN;
              col   <= col + CW'(1);
            end else if (nx < 0) begin
              rem_x <= nx + SPAN;
              col   <= col - CW'(1);
            end else begin
              rem_x <= nx;
            end
            if (ny >= SPAN) begin
              rem_y <= ny - SPAN;
              row   <= row + CW'(1);
            end else if (ny < 0) begin
              rem_y <= ny + SPAN;
              row   <= row - CW'(1);
            end else begin
              rem_y <= ny;
            end
          end
        end
        S_MUL: begin
          prod  <= co_pos ? d * co[14:0] : '0;
          sq    <= d * d;
          state <= S_CORR;
        end
        S_CORR: begin
          // A zero product from a non-positive cosine gives a zero depth here.
          corr  <= corr_sum[DW+14:15];
          state <= S_DIV_HT;
        end
        S_DIV_HT: begin
          res.corrected_depth <= 9'(corr);
          if (corr == '0) begin
            res.slice_height <= 16'(HEIGHT_MAX);
            res.slice_top    <= 16'(SCREEN_MID) - 16'(HEIGHT_MAX >> 1);
            state            <= S_DIV_SHADE;
          end else if (div_done) begin
            res.slice_height <= div_quo[15:0];
            res.slice_top    <= 16'(SCREEN_MID) - 16'(div_quo[15:1]);
            state            <= S_DIV_SHADE;
          end
        end
        S_DIV_SHADE: begin
          if (div_done) begin
            res.shade <= div_quo[7:0];
            state     <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_data  <= res;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The march keeps both remainders normalized into one cell span.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_MARCH) |-> (rem_x >= 0 && rem_x < SPAN && rem_y >= 0 && rem_y < SPAN))
    else $error("march remainder left its cell span");

  // The depth counter never passes the last step.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_MARCH) |-> (d <= D_LAST))
    else $error("march depth past limit");

  // A quotient only arrives while the sequencer waits for one.
  assert property (@(posedge clk) disable iff (rst)
    div_done |-> (div_wait && (state == S_DIV_HT || state == S_DIV_SHADE)))
    else $error("divider finished outside a division step");

  // A result without a wall carries no height.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && (!out_valid || out_ready)) |=>
      (out_data.hit || out_data.slice_height == 16'd0))
    else $error("missed ray reported a height");

endmodule
`default_nettype wire
